/* src/tlpt_pkg.sv */
package tlpt_pkg;

    localparam int FIRST_LEVEL_ENTRIES_DEF  = 16;
    localparam int SECOND_LEVEL_ENTRIES_DEF = 16;
    localparam int PROCESS_COUNT_DEF        = 4;

    localparam int ADDR_W      = 32;
    localparam int PROC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int IDX_W       = 10;
    localparam int OFFSET_W    = 12;
    localparam int SHIFT_TABLE = 22;
    localparam int SHIFT_SLOT  = 12;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_XLATE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NO_SPACE   = 2'd1,
        STATUS_NOT_MAPPED = 2'd2
    } t_status;

endpackage

/* src/tlpt_in_if.sv */
interface tlpt_in_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [tlpt_pkg::PROC_W-1:0]   process;
    logic [tlpt_pkg::ADDR_W-1:0]   phys_addr;
    logic [tlpt_pkg::ADDR_W-1:0]   virt_addr;

    modport source (output valid, output mode, output process, output phys_addr,
                    output virt_addr, input ready);
    modport sink   (input valid, input mode, input process, input phys_addr,
                    input virt_addr, output ready);
endinterface

/* src/tlpt_out_if.sv */
interface tlpt_out_if;
    logic                          valid;
    logic                          ready;
    logic [tlpt_pkg::ADDR_W-1:0]   virt_result;
    logic [tlpt_pkg::ADDR_W-1:0]   phys_result;
    logic [tlpt_pkg::STATUS_W-1:0] status;

    modport source (output valid, output virt_result, output phys_result, output status,
                    input ready);
    modport sink   (input valid, input virt_result, input phys_result, input status,
                    output ready);
endinterface

/* src/tlpt_ram.sv */
module tlpt_ram #(
    parameter int WIDTH = tlpt_pkg::ADDR_W,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                       i_wdata,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/two_level_page_table_alloc_translate.sv */
// Per-process two-level page table. Mode 0 records phys_addr in the next free slot of the
// process and returns its virtual address (table index at bit 22, slot index at bit 12);
// mode 1 looks up a virtual address (low 12 offset bits ignored) and returns the stored
// physical address. Status 1 means the process has no free slot (or does not exist),
// status 2 means the address is not mapped. Every item passes four steps (accept, lookup, slot
// memory access, result), and the output register loads in the result step; the slot memory
// is single-port with a registered read. One item is in flight at a time: the next item is
// accepted only after the previous result has loaded into the output register, and it can be
// accepted while that result still waits; a result that cannot load because the output is
// stalled holds the block in its last step.
// Since slots and tables fill strictly in order and are never freed, the valid and full
// state of each process is a pair of counters (full tables, slots used in the current
// table), so the slot memory needs no clearing after reset and the block is ready right out
// of reset.
module two_level_page_table_alloc_translate #(
    parameter int FIRST_LEVEL_ENTRIES  = tlpt_pkg::FIRST_LEVEL_ENTRIES_DEF,
    parameter int SECOND_LEVEL_ENTRIES = tlpt_pkg::SECOND_LEVEL_ENTRIES_DEF,
    parameter int PROCESS_COUNT        = tlpt_pkg::PROCESS_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tlpt_in_if.sink           i_in,
    tlpt_out_if.source        o_out
);
    localparam int TABLES = PROCESS_COUNT * FIRST_LEVEL_ENTRIES;
    localparam int SLOTS  = TABLES * SECOND_LEVEL_ENTRIES;
    localparam int AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PIW    = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;
    localparam int NW     = $clog2(FIRST_LEVEL_ENTRIES + 1);
    localparam int FW     = $clog2(SECOND_LEVEL_ENTRIES + 1);
    localparam int CW     = tlpt_pkg::IDX_W + 1;
    localparam int PW     = tlpt_pkg::PROC_W;
    localparam int DW     = tlpt_pkg::ADDR_W;
    localparam int XW     = tlpt_pkg::IDX_W;

    typedef enum logic [1:0] {ST_IDLE, ST_LOOKUP, ST_ACCESS, ST_FINISH} t_state;

    t_state             r_state;
    logic               r_mode;
    logic [PW-1:0]      r_proc;
    logic [DW-1:0]      r_pa;
    logic [DW-1:0]      r_va;
    logic [NW-1:0]      r_nf   [PROCESS_COUNT];
    logic [FW-1:0]      r_fill [PROCESS_COUNT];
    logic [PIW-1:0]     r_idx;
    logic [AW-1:0]      r_addr;
    logic               r_write;
    logic               r_hit;
    tlpt_pkg::t_status  r_status;
    logic [DW-1:0]      r_virt;
    logic               r_out_valid;
    logic [DW-1:0]      r_out_virt;
    logic [DW-1:0]      r_out_phys;
    tlpt_pkg::t_status  r_out_status;

    logic               proc_ok;
    logic [PW+3:0]      proc_ext;
    logic [PIW-1:0]     proc_idx;
    logic [NW-1:0]      cur_nf;
    logic [FW-1:0]      cur_fill;
    logic [XW-1:0]      va_t, va_s, alloc_t, alloc_s, t_sel, s_sel;
    logic [CW-1:0]      nf_cmp, fill_cmp, va_t_cmp, va_s_cmp;
    logic               alloc_ok, xlate_ok;
    logic [AW-1:0]      tbl_idx, slot_addr;
    logic [FW-1:0]      fill_inc;
    logic [DW-1:0]      ram_rdata;
    logic               ram_we;

    // lookup stage: decode against the per-process fill counters
    always_comb begin
        proc_ok  = {3'b000, r_proc} < 5'(PROCESS_COUNT);
        proc_ext = (PW + 4)'(r_proc);
        proc_idx = proc_ok ? proc_ext[PIW-1:0] : '0;
        cur_nf   = r_nf[proc_idx];
        cur_fill = r_fill[proc_idx];
        va_t     = r_va[tlpt_pkg::SHIFT_TABLE +: XW];
        va_s     = r_va[tlpt_pkg::SHIFT_SLOT +: XW];
        alloc_t  = XW'(cur_nf);
        alloc_s  = XW'(cur_fill);
        nf_cmp   = CW'(cur_nf);
        fill_cmp = CW'(cur_fill);
        va_t_cmp = CW'(va_t);
        va_s_cmp = CW'(va_s);
        alloc_ok = proc_ok && (nf_cmp != CW'(FIRST_LEVEL_ENTRIES));
        // a slot is mapped if its table is already full, or it lies below the fill mark
        xlate_ok = proc_ok && (va_t_cmp < CW'(FIRST_LEVEL_ENTRIES))
                   && (va_s_cmp < CW'(SECOND_LEVEL_ENTRIES))
                   && ((va_t_cmp < nf_cmp) || ((va_t_cmp == nf_cmp) && (va_s_cmp < fill_cmp)));
        t_sel     = (r_mode == tlpt_pkg::MODE_ALLOC) ? alloc_t : va_t;
        s_sel     = (r_mode == tlpt_pkg::MODE_ALLOC) ? alloc_s : va_s;
        tbl_idx   = AW'(proc_idx) * AW'(FIRST_LEVEL_ENTRIES) + AW'(t_sel);
        slot_addr = tbl_idx * AW'(SECOND_LEVEL_ENTRIES) + AW'(s_sel);
        fill_inc  = r_fill[r_idx] + FW'(1);
    end

    assign ram_we = (r_state == ST_ACCESS) && r_write;

    tlpt_ram #(
        .WIDTH (DW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (r_addr),
        .i_wdata (r_pa),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_write     <= 1'b0;
            r_hit       <= 1'b0;
            for (int p = 0; p < PROCESS_COUNT; p++) begin
                r_nf[p]   <= '0;
                r_fill[p] <= '0;
            end
        end else begin
            // in ST_FINISH the output register is handled by the load below
            if (r_out_valid && o_out.ready && (r_state != ST_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_mode  <= i_in.mode;
                        r_proc  <= i_in.process;
                        r_pa    <= i_in.phys_addr;
                        r_va    <= i_in.virt_addr;
                        r_state <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP: begin
                    r_idx  <= proc_idx;
                    r_addr <= slot_addr;
                    if (r_mode == tlpt_pkg::MODE_ALLOC) begin
                        r_write  <= alloc_ok;
                        r_hit    <= 1'b0;
                        r_status <= alloc_ok ? tlpt_pkg::STATUS_OK : tlpt_pkg::STATUS_NO_SPACE;
                        r_virt   <= alloc_ok
                            ? {alloc_t, alloc_s, {tlpt_pkg::OFFSET_W{1'b0}}} : '0;
                    end else begin
                        r_write  <= 1'b0;
                        r_hit    <= xlate_ok;
                        r_status <= xlate_ok ? tlpt_pkg::STATUS_OK
                                             : tlpt_pkg::STATUS_NOT_MAPPED;
                        r_virt   <= '0;
                    end
                    r_state <= ST_ACCESS;
                end
                ST_ACCESS: begin
                    if (r_write) begin
                        if (fill_inc == FW'(SECOND_LEVEL_ENTRIES)) begin
                            r_fill[r_idx] <= '0;
                            r_nf[r_idx]   <= r_nf[r_idx] + NW'(1);
                        end else begin
                            r_fill[r_idx] <= fill_inc;
                        end
                    end
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_virt   <= r_virt;
                        r_out_phys   <= r_hit ? ram_rdata : '0;
                        r_out_status <= r_status;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.virt_result = r_out_virt;
    assign o_out.phys_result = r_out_phys;
    assign o_out.status      = r_out_status;
endmodule

/* src/tlpt_chk.sv */
module tlpt_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [tlpt_pkg::ADDR_W-1:0]   i_out_virt,
    input logic [tlpt_pkg::ADDR_W-1:0]   i_out_phys,
    input logic [tlpt_pkg::STATUS_W-1:0] i_out_status
);
    // a failed beat carries no addresses, and the status code is one of the three
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != tlpt_pkg::STATUS_OK)
        |-> (i_out_virt == '0) && (i_out_phys == '0)
            && ((i_out_status == tlpt_pkg::STATUS_NO_SPACE)
                || (i_out_status == tlpt_pkg::STATUS_NOT_MAPPED)))
        else $error("failed beat with nonzero address or bad status");

    a_page_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_virt[tlpt_pkg::OFFSET_W-1:0] == '0))
        else $error("virtual result not page aligned");

    // one item in flight: input closes right after a beat is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after accept");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_virt)
            && $stable(i_out_phys) && $stable(i_out_status))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind two_level_page_table_alloc_translate tlpt_chk u_tlpt_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_virt   (o_out.virt_result),
    .i_out_phys   (o_out.phys_result),
    .i_out_status (o_out.status)
);
